// ===== hdl/des_pkg.sv =====
// Package: DES tables, permutation helpers and shared types.
package des_pkg;

    localparam int MaxRounds = 16;
    localparam int RndW      = 5;

    typedef logic [47:0] subkey_t;
    typedef logic [5:0]  sbox_row_t;

    typedef enum logic [0:0] {
        CFG_KEY    = 1'b0,
        CFG_ROUNDS = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } cmd_t;

    // Status carried down the round pipeline alongside each block
    typedef struct packed {
        logic              valid;
        logic              decrypt;
        logic [RndW-1:0]   rounds;
    } stage_ctrl_t;

    localparam logic [6:0] TAB_IP [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };
    localparam logic [6:0] TAB_FP [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };
    localparam logic [6:0] TAB_E [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1 };
    localparam logic [6:0] TAB_P [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25 };
    localparam logic [6:0] TAB_PC1 [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4 };
    localparam logic [6:0] TAB_PC2 [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32 };
    localparam logic [1:0] TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
    localparam logic [3:0] TAB_S [8][64] = '{
     '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
       4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
     '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
       0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
     '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
       13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
     '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
       10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
     '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
       4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
     '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
       9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
     '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
       1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
     '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
       7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    // Fixed bit permutations: pure wiring
    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(TAB_IP[i])];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(TAB_FP[i])];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64 - int'(TAB_PC1[i])];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56 - int'(TAB_PC2[i])];
        return r;
    endfunction

    function automatic logic [27:0] rot28(input logic [27:0] x, input logic [1:0] s);
        logic [27:0] r;
        r = (s == 2'd2) ? {x[25:0], x[27:26]} : {x[26:0], x[27]};
        return r;
    endfunction

    // DES round function: expansion, key mix, S-boxes, P
    function automatic logic [31:0] feistel(input logic [31:0] half, input subkey_t k);
        logic [47:0] x;
        logic [31:0] f;
        logic [31:0] r;
        sbox_row_t   piece;
        for (int i = 0; i < 48; i++) x[47-i] = half[32 - int'(TAB_E[i])];
        x = x ^ k;
        for (int i = 0; i < 8; i++) begin
            piece = x[47-6*i -: 6];
            f[31-4*i -: 4] = TAB_S[i][{piece[5], piece[0], piece[4:1]}];
        end
        for (int i = 0; i < 32; i++) r[31-i] = f[32 - int'(TAB_P[i])];
        return r;
    endfunction

endpackage

// ===== hdl/des_key_sched.sv =====
// Round key schedule: all round subkeys of the configured key, registered.
module des_key_sched
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [63:0]           cipher_key,
    output des_pkg::subkey_t      subkeys [des_pkg::MaxRounds]
);

    logic [55:0] cd_perm;
    logic [27:0] c_half [des_pkg::MaxRounds+1];
    logic [27:0] d_half [des_pkg::MaxRounds+1];
    des_pkg::subkey_t subkeys_reg [des_pkg::MaxRounds];

    // Rotation wiring; user keeps key static while items in flight, unenforced
    always_comb
    begin
        cd_perm   = des_pkg::perm_pc1(cipher_key);
        c_half[0] = cd_perm[55:28];
        d_half[0] = cd_perm[27:0];
        for (int i = 0; i < des_pkg::MaxRounds; i++)
        begin
            c_half[i+1] = des_pkg::rot28(c_half[i], des_pkg::TAB_ROT[i]);
            d_half[i+1] = des_pkg::rot28(d_half[i], des_pkg::TAB_ROT[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < des_pkg::MaxRounds; i++) subkeys_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < des_pkg::MaxRounds; i++)
                subkeys_reg[i] <= des_pkg::perm_pc2({c_half[i+1], d_half[i+1]});
        end
    end

    assign subkeys = subkeys_reg;

endmodule

// ===== hdl/des_round.sv =====
// One Feistel round stage; passes the block on unchanged past the round count.
module des_round
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [4:0]             round_idx,
    input  des_pkg::subkey_t       key_fwd,
    input  des_pkg::subkey_t       key_rev,
    input  des_pkg::stage_ctrl_t   ctrl_in,
    input  logic [63:0]            lr_in,
    output des_pkg::stage_ctrl_t   ctrl_out,
    output logic [63:0]            lr_out
);

    des_pkg::stage_ctrl_t ctrl_reg;
    logic [63:0]          lr_reg;
    logic [63:0]          lr_next;
    des_pkg::subkey_t     key_sel;

    // Round logic; decryption takes key (n-1-i) from the reversed bank
    always_comb
    begin
        key_sel = ctrl_in.decrypt ? key_rev : key_fwd;
        if (round_idx < ctrl_in.rounds)
            lr_next = {lr_in[31:0], des_pkg::feistel(lr_in[31:0], key_sel) ^ lr_in[63:32]};
        else
            lr_next = lr_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else
            ctrl_reg <= ctrl_in;
    end

    always_ff @(posedge clk)
    begin
        lr_reg <= lr_next;
    end

    assign ctrl_out = ctrl_reg;
    assign lr_out   = lr_reg;

endmodule

// ===== hdl/des_block_cipher.sv =====
// Top level: DES pipeline with configuration registers and key schedule.
// Pipeline from start to done: input stage, 16 round stages, output stage.
// Throughput: one block per cycle; busy stays low, the 16 unrolled rounds are the pipeline.
// Rounds beyond round_count pass the block through, so latency does not vary.
// Reset: key 0, round count 16, pipeline empty; done cannot be held off.
// After a key write, subkeys settle once key_reg and then the subkey registers have been loaded.
module des_block_cipher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [63:0] data_block,
    output logic        done,
    output logic [63:0] result_block,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int N = des_pkg::MaxRounds;

    logic [63:0]          key_reg;
    logic [4:0]           rounds_reg;
    des_pkg::subkey_t     subkeys [N];
    des_pkg::stage_ctrl_t ctrl [N+1];
    logic [63:0]          lr [N+1];
    des_pkg::stage_ctrl_t in_ctrl_reg;
    logic [63:0]          in_lr_reg;
    logic                 done_reg;
    logic [63:0]          result_reg;
    logic [4:0]           sat_rounds;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            rounds_reg <= 5'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (des_pkg::cfg_index_t'(cfg_index))
                des_pkg::CFG_KEY:    key_reg    <= cfg_data;
                des_pkg::CFG_ROUNDS: rounds_reg <= cfg_data[4:0];
                default:             key_reg    <= key_reg;
            endcase
        end
    end

    assign sat_rounds = (rounds_reg > 5'(N)) ? 5'(N) : rounds_reg;

    des_key_sched u_keys
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cipher_key (key_reg),
        .subkeys (subkeys)
    );

    // Input stage: initial permutation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ctrl_reg <= '0;
        else
            in_ctrl_reg <= '{valid: start && !busy, decrypt: command, rounds: sat_rounds};
    end

    always_ff @(posedge clk)
    begin
        in_lr_reg <= des_pkg::perm_ip(data_block);
    end

    assign ctrl[0] = in_ctrl_reg;
    assign lr[0]   = in_lr_reg;

    // Round stages; reversed key index n-1-i is picked from a mux per stage
    for (genvar g = 0; g < N; g++)
    begin : g_round
        logic [4:0]       rev_idx;
        des_pkg::subkey_t key_rev;
        assign rev_idx = ctrl[g].rounds - 5'd1 - 5'(g);
        assign key_rev = subkeys[rev_idx[3:0]];

        des_round u_round
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .round_idx (5'(g)),
            .key_fwd   (subkeys[g]),
            .key_rev   (key_rev),
            .ctrl_in   (ctrl[g]),
            .lr_in     (lr[g]),
            .ctrl_out  (ctrl[g+1]),
            .lr_out    (lr[g+1])
        );
    end

    // Output stage: half swap and final permutation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctrl[N].valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= des_pkg::perm_fp({lr[N][31:0], lr[N][63:32]});
    end

    assign done         = done_reg;
    assign result_block = result_reg;

    // A block leaving the last round appears as a result in the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl[N].valid |=> done)
        else $error("result strobe lost");
    // Every accepted block surfaces at done after the input, round and output stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##18 done)
        else $error("pipeline latency broken");
    // Round count in flight never exceeds the round limit
    a_rounds_sat: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl[0].valid |-> ctrl[0].rounds <= 5'(N))
        else $error("round count not saturated");

endmodule
